// File: design/svxd_pkg.sv
// ----------------------------------------------------------------------------
// svxd_pkg
// Shared types, constants and helpers for the half-block sprite display.
// ----------------------------------------------------------------------------
`default_nettype none

package svxd_pkg;

    localparam int DISPLAY_WIDTH  = 64;
    localparam int DISPLAY_HEIGHT = 32;
    localparam int CHAR_ROWS      = DISPLAY_HEIGHT / 2;

    // One lane (column bank) per sprite pixel
    localparam int LANES      = 8;
    localparam int LANE_W     = $clog2(LANES);
    localparam int COL_W      = $clog2(DISPLAY_WIDTH);
    localparam int Y_W        = $clog2(DISPLAY_HEIGHT);
    localparam int PY_W       = $clog2(DISPLAY_HEIGHT + 16);
    localparam int COL_GROUPS = (DISPLAY_WIDTH + LANES - 1) / LANES;
    localparam int BANK_DEPTH = CHAR_ROWS * COL_GROUPS;
    localparam int ADDR_W     = $clog2(BANK_DEPTH);
    localparam int CODE_W     = 8;

    localparam logic [CODE_W-1:0] CODE_SPACE = 8'h20;

    localparam logic [CODE_W-1:0] XOR_MASKS [8] = '{
        8'hFF, 8'hFC, 8'h07, 8'h04, 8'h07, 8'hFC, 8'hFF, 8'h04
    };

    typedef enum logic [1:0] {
        CMD_DRAW  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_SWEEP = 3'b100
    } state_t;

    // Per-lane access for one transaction
    typedef struct packed {
        logic              pix_en;
        logic              parity;
        logic [ADDR_W-1:0] addr;
    } lane_req_t;

    // Clearing pass write, shared by all lanes
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
    } clr_t;

    typedef struct packed {
        logic              collision;
        logic [CODE_W-1:0] cell_value;
    } result_t;

    // Selections that turn a lit pixel off
    function automatic logic sel_collides(input logic [2:0] sel);
        logic hit;
        begin
            case (sel)
                3'd2, 3'd3, 3'd5, 3'd6: hit = 1'b1;
                default:                hit = 1'b0;
            endcase
            return hit;
        end
    endfunction

    // x mod DISPLAY_WIDTH; the width is a power of two, so keep the low bits
    function automatic logic [COL_W-1:0] mod_width(input logic [7:0] v);
        return COL_W'(v);
    endfunction

    // y mod DISPLAY_HEIGHT; the height is a power of two
    function automatic logic [Y_W-1:0] mod_height(input logic [7:0] v);
        return Y_W'(v);
    endfunction

endpackage

`default_nettype wire

// File: design/svxd_ram.sv
// ----------------------------------------------------------------------------
// svxd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module svxd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/svxd_lane.sv
// ----------------------------------------------------------------------------
// svxd_lane
// One column bank: cell storage plus read-modify-write of one pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module svxd_lane (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic                       exec,
    input  wire svxd_pkg::lane_req_t        req,
    input  wire svxd_pkg::clr_t             clr,
    output logic                            coll,
    output logic [svxd_pkg::CODE_W-1:0]     rd_data
);
    import svxd_pkg::*;

    logic              en_reg;
    logic              en_next;
    logic              parity_reg;
    logic [ADDR_W-1:0] addr_reg;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CODE_W-1:0] wdata;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] new_code;
    logic [2:0]        sel;

    svxd_ram #(
        .WIDTH (CODE_W),
        .DEPTH (BANK_DEPTH)
    ) u_bank (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (req.addr),
        .rdata (code)
    );

    assign en_next = accept ? req.pix_en : en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg <= 1'b0;
        end
        else
        begin
            en_reg <= en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            parity_reg <= req.parity;
            addr_reg   <= req.addr;
        end
    end

    // sel = parity | (code & 6)
    assign sel      = {code[2], code[1], parity_reg};
    assign new_code = code ^ XOR_MASKS[sel];

    assign we    = (exec && en_reg) || clr.we;
    assign waddr = clr.we ? clr.addr : addr_reg;
    assign wdata = clr.we ? CODE_SPACE : new_code;

    assign coll    = exec && en_reg && sel_collides(sel);
    assign rd_data = code;

endmodule

`default_nettype wire

// File: design/svxd_merge.sv
// ----------------------------------------------------------------------------
// svxd_merge
// Combines lane outputs into one result and the next collision flag.
// ----------------------------------------------------------------------------
`default_nettype none

module svxd_merge (
    input  wire svxd_pkg::cmd_t                                 cmd,
    input  wire logic                                           last_row,
    input  wire logic [svxd_pkg::LANE_W-1:0]                    rd_lane,
    input  wire logic                                           rd_ok,
    input  wire logic                                           flag,
    input  wire logic [svxd_pkg::LANES-1:0]                     lane_coll,
    input  wire logic [svxd_pkg::LANES-1:0][svxd_pkg::CODE_W-1:0] lane_data,
    output svxd_pkg::result_t                                   res,
    output logic                                                flag_next
);
    import svxd_pkg::*;

    logic merged;

    always_comb
    begin
        merged         = flag | (|lane_coll);
        res.collision  = merged;
        res.cell_value = '0;
        if (cmd == CMD_READ && rd_ok)
        begin
            res.cell_value = lane_data[rd_lane];
        end
        // last row of a sprite ends accumulation after reporting
        flag_next = (cmd == CMD_DRAW && last_row) ? 1'b0 : merged;
    end

endmodule

`default_nettype wire

// File: design/sprite_xor_draw_half_block.sv
// ----------------------------------------------------------------------------
// sprite_xor_draw_half_block
// 64x32 XOR sprite display stored as half-block character cells.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low; cmd and the
//   other input fields are sampled at that edge. Every transaction returns
//   exactly one result: done is high for one cycle with collision and
//   cell_value valid. The receiver cannot stall; results are never held.
//   Draw, read and unused commands step through accept, read-modify-write
//   across the eight column-bank lanes in the exec state, then done; the
//   exec state is there for the registered read of the bank RAMs. The
//   next transaction can be accepted in the cycle done is high.
//   Clear walks all 128 bank addresses, writing one group of eight cells
//   per cycle, with done in the cycle after the last write.
//   After reset the same clearing pass runs with busy high and no done;
//   the collision flag resets to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_xor_draw_half_block (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] cmd,
    input  wire logic [7:0] x_pos,
    input  wire logic [7:0] y_pos,
    input  wire logic [3:0] row_index,
    input  wire logic [7:0] row_byte,
    input  wire logic       last_row,
    input  wire logic [5:0] cell_col,
    input  wire logic [3:0] cell_row,
    output logic            done,
    output logic            collision,
    output logic [7:0]      cell_value
);
    import svxd_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [ADDR_W-1:0] sweep_cnt_reg;
    logic [ADDR_W-1:0] sweep_cnt_next;
    logic              clr_cmd_reg;
    logic              clr_cmd_next;
    logic              flag_reg;
    logic              flag_next;
    logic              done_reg;
    logic              done_next;
    logic              collision_reg;
    logic              collision_next;
    logic [CODE_W-1:0] cell_value_reg;
    logic [CODE_W-1:0] cell_value_next;

    cmd_t              cmd_reg;
    logic              last_reg;
    logic [LANE_W-1:0] rd_lane_reg;
    logic              rd_ok_reg;

    logic              accept;
    cmd_t              cmd_in;
    logic [COL_W-1:0]  xs;
    logic [Y_W-1:0]    ys;
    logic [PY_W-1:0]   py;
    logic              row_ok;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_ok;

    lane_req_t                      lane_req [LANES];
    clr_t                           clr;
    logic [LANES-1:0]               lane_coll;
    logic [LANES-1:0][CODE_W-1:0]   lane_data;
    result_t                        merge_res;
    logic                           merge_flag;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign cmd_in = cmd_t'(cmd);

    assign xs     = mod_width(x_pos);
    assign ys     = mod_height(y_pos);
    assign py     = PY_W'(ys) + PY_W'(row_index);
    assign row_ok = (py < PY_W'(DISPLAY_HEIGHT));

    assign rd_addr = ADDR_W'(cell_row * COL_GROUPS) + ADDR_W'(cell_col >> LANE_W);
    assign rd_ok   = (8'(cell_col) < 8'(DISPLAY_WIDTH)) && (6'(cell_row) < 6'(CHAR_ROWS));

    // Lane b owns columns with col mod 8 == b; sprite pixel i lands in one lane
    always_comb
    begin
        logic [LANE_W-1:0] ofs;
        logic [COL_W:0]    col;
        logic [ADDR_W-1:0] draw_addr;
        for (int b = 0; b < LANES; b++)
        begin
            ofs       = LANE_W'(b) - xs[LANE_W-1:0];
            col       = (COL_W+1)'(xs) + (COL_W+1)'(ofs);
            draw_addr = ADDR_W'(py[PY_W-1:1] * COL_GROUPS) + ADDR_W'(col >> LANE_W);
            lane_req[b].pix_en = (cmd_in == CMD_DRAW) && row_ok && row_byte[~ofs]
                                 && (col < (COL_W+1)'(DISPLAY_WIDTH));
            lane_req[b].parity = py[0];
            lane_req[b].addr   = (cmd_in == CMD_READ) ? rd_addr : draw_addr;
        end
    end

    assign clr.we   = (state_reg == ST_SWEEP);
    assign clr.addr = sweep_cnt_reg;

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        svxd_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .accept  (accept),
            .exec    (state_reg == ST_EXEC),
            .req     (lane_req[g]),
            .clr     (clr),
            .coll    (lane_coll[g]),
            .rd_data (lane_data[g])
        );
    end

    svxd_merge u_merge (
        .cmd       (cmd_reg),
        .last_row  (last_reg),
        .rd_lane   (rd_lane_reg),
        .rd_ok     (rd_ok_reg),
        .flag      (flag_reg),
        .lane_coll (lane_coll),
        .lane_data (lane_data),
        .res       (merge_res),
        .flag_next (merge_flag)
    );

    always_comb
    begin
        state_next      = state_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        clr_cmd_next    = clr_cmd_reg;
        flag_next       = flag_reg;
        done_next       = 1'b0;
        collision_next  = collision_reg;
        cell_value_next = cell_value_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd_in == CMD_CLEAR)
                    begin
                        state_next     = ST_SWEEP;
                        sweep_cnt_next = '0;
                        clr_cmd_next   = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                done_next       = 1'b1;
                collision_next  = merge_res.collision;
                cell_value_next = merge_res.cell_value;
                flag_next       = merge_flag;
                state_next      = ST_IDLE;
            end
            ST_SWEEP:
            begin
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                if (sweep_cnt_reg == ADDR_W'(BANK_DEPTH - 1))
                begin
                    state_next   = ST_IDLE;
                    clr_cmd_next = 1'b0;
                    // the pass after reset gives no result
                    if (clr_cmd_reg)
                    begin
                        done_next       = 1'b1;
                        collision_next  = flag_reg;
                        cell_value_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_cnt_reg  <= '0;
            clr_cmd_reg    <= 1'b0;
            flag_reg       <= 1'b0;
            done_reg       <= 1'b0;
            collision_reg  <= 1'b0;
            cell_value_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            clr_cmd_reg    <= clr_cmd_next;
            flag_reg       <= flag_next;
            done_reg       <= done_next;
            collision_reg  <= collision_next;
            cell_value_reg <= cell_value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= cmd_in;
            last_reg    <= last_row;
            rd_lane_reg <= cell_col[LANE_W-1:0];
            rd_ok_reg   <= rd_ok;
        end
    end

    assign done       = done_reg;
    assign collision  = collision_reg;
    assign cell_value = cell_value_reg;

endmodule

`default_nettype wire

// File: design/svxd_checker.sv
// ----------------------------------------------------------------------------
// svxd_checker
// Port-level checks on the sprite display, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module svxd_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       busy,
    input  wire logic [1:0] cmd,
    input  wire logic       done,
    input  wire logic [7:0] cell_value
);
    import svxd_pkg::*;

    // Results are single-cycle pulses and never back to back
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done high on two consecutive cycles");

    // Non-clear transactions pass through a busy exec state and then show done
    a_short_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd != CMD_CLEAR) |=> busy ##1 done)
        else $error("draw/read transaction did not finish in two cycles");

    // Block is ready again when a result is shown
    a_ready_at_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy while result is shown");

    // A nonzero result can only be one of the four half-block codes
    a_valid_code: assert property (@(posedge clk) disable iff (!rst_n)
        (done && cell_value != 8'h00) |->
            (cell_value == 8'h20 || cell_value == 8'hDF ||
             cell_value == 8'hDC || cell_value == 8'hDB))
        else $error("read returned an invalid cell code");

endmodule

bind sprite_xor_draw_half_block svxd_checker u_svxd_checker (.*);

`default_nettype wire
